/* rtl/core/pitrc_pkg.sv */
// ----------------------------------------------------------------------------
// pitrc_pkg: shared constants for the point-in-triangle ray crossing unit
// Coordinate width default, far point of the cast segment and stream widths.
// ----------------------------------------------------------------------------
package pitrc_pkg;

  // default coordinate width in bits, two's complement
  localparam int CoordWidthDef = 17;

  // far end of the cast segment, same value on both axes
  localparam int FarCoord = 100000;

  // signed width that holds FarCoord
  localparam int FarWidth = 18;

  // result stream: inside_res, crossings, padded to one byte
  localparam int ResWidth      = 3;
  localparam int ResTdataWidth = 8;

  localparam int NumEdges = 3;

endpackage

/* rtl/core/point_in_triangle_ray_crossing_unit.sv */
// ----------------------------------------------------------------------------
// point_in_triangle_ray_crossing_unit: point-in-triangle test by ray crossing
// Registered query, three parallel edge tests, registered result.
// ----------------------------------------------------------------------------
// Takes one query per transaction: point P and corners A, B, C as signed
// COORD_WIDTH-bit integers, and returns one result per query with the number
// of edges crossed by the segment from P to (100000, 100000) and an inside
// flag set when that number is odd. Arithmetic is exact integer. The unit
// accepts a new query in every cycle while not stalled; an accepted query is
// loaded into the input register and then its result into the result
// register, and the edge tests run side by side between those registers. Both
// registers stall together only when a result is waiting and the output side
// is not ready.
module point_in_triangle_ray_crossing_unit #(
  parameter int COORD_WIDTH = pitrc_pkg::CoordWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // query stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // from bit 0: point_x, point_y, corner_a_x, corner_a_y, corner_b_x,
  // corner_b_y, corner_c_x, corner_c_y, each COORD_WIDTH bits
  input  logic [8*COORD_WIDTH-1:0] s_axis_tdata,
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // from bit 0: inside_res (1), crossings (2), zero padding
  output logic [pitrc_pkg::ResTdataWidth-1:0] m_axis_tdata
);

  localparam int W = COORD_WIDTH;

  logic                 in_valid_q, in_valid_d;
  logic [8*W-1:0]       in_data_q;
  logic                 out_valid_q, out_valid_d;
  logic [pitrc_pkg::ResWidth-1:0] res_q, res_d;
  logic                 advance;
  logic                 in_take;

  logic signed [W-1:0]  px, py, ax, ay, bx, by, cx, cy;
  logic [pitrc_pkg::NumEdges-1:0] hit;
  logic [1:0]           count;

  // result register moves when empty or drained
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  assign in_valid_d  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? in_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= s_axis_tdata;
    end
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign px = $signed(in_data_q[0*W +: W]);
  assign py = $signed(in_data_q[1*W +: W]);
  assign ax = $signed(in_data_q[2*W +: W]);
  assign ay = $signed(in_data_q[3*W +: W]);
  assign bx = $signed(in_data_q[4*W +: W]);
  assign by = $signed(in_data_q[5*W +: W]);
  assign cx = $signed(in_data_q[6*W +: W]);
  assign cy = $signed(in_data_q[7*W +: W]);

  pitrc_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_ab (
    .px_i(px), .py_i(py), .ux_i(ax), .uy_i(ay), .vx_i(bx), .vy_i(by),
    .crossed_o(hit[0])
  );

  pitrc_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_bc (
    .px_i(px), .py_i(py), .ux_i(bx), .uy_i(by), .vx_i(cx), .vy_i(cy),
    .crossed_o(hit[1])
  );

  pitrc_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_ca (
    .px_i(px), .py_i(py), .ux_i(cx), .uy_i(cy), .vx_i(ax), .vy_i(ay),
    .crossed_o(hit[2])
  );

  assign count = 2'({1'b0, hit[0]}) + 2'({1'b0, hit[1]}) + 2'({1'b0, hit[2]});
  assign res_d = {count, count[0]};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pitrc_pkg::ResTdataWidth'(res_q);

`ifndef SYNTHESIS
  a_take_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_valid_q)
    else $error("accepted query did not reach the input register");

  a_advance_fills_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && advance) |=> out_valid_q)
    else $error("query in flight did not reach the result register");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_data_q)))
    else $error("stalled query lost from the input register");

  a_inside_is_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == m_axis_tdata[1]))
    else $error("inside flag disagrees with crossing count parity");

  a_empty_is_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("empty input register refused a transaction");
`endif

endmodule

/* rtl/core/pitrc_edge.sv */
// ----------------------------------------------------------------------------
// pitrc_edge: segment against one triangle edge
// Forms the three cross products for edge U-V and flags a proper crossing of
// the segment from P to the far point, or a parallel edge whose numerator vanishes, without any division.
// ----------------------------------------------------------------------------
module pitrc_edge #(
  parameter int COORD_WIDTH = pitrc_pkg::CoordWidthDef
) (
  input  logic signed [COORD_WIDTH-1:0] px_i,
  input  logic signed [COORD_WIDTH-1:0] py_i,
  input  logic signed [COORD_WIDTH-1:0] ux_i,
  input  logic signed [COORD_WIDTH-1:0] uy_i,
  input  logic signed [COORD_WIDTH-1:0] vx_i,
  input  logic signed [COORD_WIDTH-1:0] vy_i,
  output logic                          crossed_o
);

  // edge and offset differences
  localparam int EW = COORD_WIDTH + 1;
  // segment direction: far point minus P
  localparam int SW = ((COORD_WIDTH > pitrc_pkg::FarWidth) ?
                       COORD_WIDTH : pitrc_pkg::FarWidth) + 1;
  // cross product width, covers every difference of two products
  localparam int PW = EW + SW + 1;

  logic signed [SW-1:0]    sx, sy;
  logic signed [EW-1:0]    ex, ey, qx, qy;
  logic signed [EW+SW-1:0] d_p0, d_p1, t2_p0, t2_p1;
  logic signed [2*EW-1:0]  t1_p0, t1_p1;
  logic signed [PW-1:0]    den, t1, t2;
  logic                    t1_ok, t2_ok;

  assign sx = SW'(pitrc_pkg::FarCoord) - SW'(px_i);
  assign sy = SW'(pitrc_pkg::FarCoord) - SW'(py_i);
  assign ex = EW'(vx_i) - EW'(ux_i);
  assign ey = EW'(vy_i) - EW'(uy_i);
  assign qx = EW'(px_i) - EW'(ux_i);
  assign qy = EW'(py_i) - EW'(uy_i);

  assign d_p0  = ey * sx;
  assign d_p1  = ex * sy;
  assign t1_p0 = ex * qy;
  assign t1_p1 = ey * qx;
  assign t2_p0 = sx * qy;
  assign t2_p1 = sy * qx;

  assign den = PW'(d_p0) - PW'(d_p1);
  assign t1  = PW'(t1_p0) - PW'(t1_p1);
  assign t2  = PW'(t2_p0) - PW'(t2_p1);

  // ratio strictly inside (0,1), sign of the denominator picks the window
  always_comb begin
    if (den > 0) begin
      t1_ok = (t1 > 0) && (t1 < den);
      t2_ok = (t2 > 0) && (t2 < den);
    end else begin
      t1_ok = (t1 < 0) && (t1 > den);
      t2_ok = (t2 < 0) && (t2 > den);
    end
  end

  // parallel edge: count it when either numerator vanishes
  assign crossed_o = (den == '0) ? ((t1 == '0) || (t2 == '0)) : (t1_ok && t2_ok);

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the point-in-triangle ray crossing unit
// Drives directed and random queries through the query stream, predicts the
// crossing count and inside flag of every query with exact integer cross
// products, and compares each result transaction against the oldest
// prediction under varying source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW       = pitrc_pkg::CoordWidthDef;
  localparam int PadWidth = pitrc_pkg::ResTdataWidth - pitrc_pkg::ResWidth;

  typedef logic signed [CW-1:0] coord_t;

  // first field in the lowest bits, so the last member comes first
  typedef struct packed {
    coord_t corner_c_y;
    coord_t corner_c_x;
    coord_t corner_b_y;
    coord_t corner_b_x;
    coord_t corner_a_y;
    coord_t corner_a_x;
    coord_t point_y;
    coord_t point_x;
  } query_t;

  typedef struct packed {
    logic [PadWidth-1:0] pad;
    logic [1:0]          crossings;
    logic                inside_res;
  } verdict_t;

  // coordinate spread used by the random generator
  typedef enum int {SPAN_FULL, SPAN_GRID, SPAN_NEAR} span_e;

  class crossing_scoreboard;
    verdict_t expected_verdicts[$];
    int       mismatch_count = 0;

    function automatic bit edge_crossed(longint px, longint py, longint ux, longint uy,
                                        longint vx, longint vy);
      longint sx, sy, ex, ey, qx, qy, d, t1, t2;
      sx = longint'(pitrc_pkg::FarCoord) - px;
      sy = longint'(pitrc_pkg::FarCoord) - py;
      ex = vx - ux;
      ey = vy - uy;
      qx = px - ux;
      qy = py - uy;
      d  = ey * sx - ex * sy;
      t1 = ex * qy - ey * qx;
      t2 = sx * qy - sy * qx;
      // parallel edge: count it when either numerator vanishes
      if (d == 0) return (t1 == 0) || (t2 == 0);
      // both parameters strictly inside the open unit interval, sign-aware
      if (d > 0) return (t1 > 0) && (t1 < d) && (t2 > 0) && (t2 < d);
      return (t1 < 0) && (t1 > d) && (t2 < 0) && (t2 > d);
    endfunction

    function automatic verdict_t predict(query_t q);
      longint   px, py, ax, ay, bx, by, cx, cy;
      int       n;
      verdict_t v;
      px = longint'(q.point_x);
      py = longint'(q.point_y);
      ax = longint'(q.corner_a_x);
      ay = longint'(q.corner_a_y);
      bx = longint'(q.corner_b_x);
      by = longint'(q.corner_b_y);
      cx = longint'(q.corner_c_x);
      cy = longint'(q.corner_c_y);
      n = int'(edge_crossed(px, py, ax, ay, bx, by))
        + int'(edge_crossed(px, py, bx, by, cx, cy))
        + int'(edge_crossed(px, py, cx, cy, ax, ay));
      v            = '0;
      v.crossings  = n[1:0];
      v.inside_res = n[0];
      return v;
    endfunction

    function void note_query(query_t q);
      expected_verdicts.push_back(predict(q));
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
    endtask

    task check_result(verdict_t got);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result transaction", int'(got), -1);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.inside_res !== want.inside_res)
        report_mismatch("inside_res", int'(got.inside_res), int'(want.inside_res));
      if (got.crossings !== want.crossings)
        report_mismatch("crossings", int'(got.crossings), int'(want.crossings));
    endtask

    function int pending();
      return expected_verdicts.size();
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [8*CW-1:0]     s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [pitrc_pkg::ResTdataWidth-1:0] m_axis_tdata;

  crossing_scoreboard sb;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  query_taken    = 1'b0;
  bit  hold_req       = 1'b0;
  bit  hold_on        = 1'b0;

  point_in_triangle_ray_crossing_unit #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 200000);
    $display("tb: failure");
    $finish;
  end

  // handshake signals only move at the rising edge, so sample them midway
  always @(negedge clk_i) begin
    query_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    if (query_taken) sb.note_query(query_t'(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(verdict_t'(m_axis_tdata));
  end

  always @(posedge clk_i) begin
    m_axis_tready <= hold_on ? 1'b0 : ($urandom_range(99) >= recv_stall_pct);
  end

  // long sink hold-off, counted here so the source keeps offering meanwhile
  initial begin
    forever begin
      wait (hold_req);
      @(posedge clk_i);
      hold_req = 1'b0;
      hold_on <= 1'b1;
      repeat (150) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  function automatic query_t make_query(int px, int py, int ax, int ay,
                                        int bx, int by, int cx, int cy);
    query_t q;
    q.point_x    = coord_t'(px);
    q.point_y    = coord_t'(py);
    q.corner_a_x = coord_t'(ax);
    q.corner_a_y = coord_t'(ay);
    q.corner_b_x = coord_t'(bx);
    q.corner_b_y = coord_t'(by);
    q.corner_c_x = coord_t'(cx);
    q.corner_c_y = coord_t'(cy);
    return q;
  endfunction

  function automatic coord_t pick_coord(span_e span, coord_t centre);
    case (span)
      SPAN_FULL: return coord_t'($urandom);
      // tiny grid: collinear and parallel edges turn up often
      SPAN_GRID: return coord_t'(int'($urandom_range(64)) - 32);
      default:   return centre + coord_t'(int'($urandom_range(4000)) - 2000);
    endcase
  endfunction

  function automatic query_t random_query();
    query_t q;
    span_e  span;
    int     roll;
    roll = $urandom_range(99);
    span = (roll < 30) ? SPAN_FULL : (roll < 65) ? SPAN_GRID : SPAN_NEAR;
    q.point_x    = pick_coord((span == SPAN_NEAR) ? SPAN_FULL : span, '0);
    q.point_y    = pick_coord((span == SPAN_NEAR) ? SPAN_FULL : span, '0);
    q.corner_a_x = pick_coord(span, q.point_x);
    q.corner_a_y = pick_coord(span, q.point_y);
    q.corner_b_x = pick_coord(span, q.point_x);
    q.corner_b_y = pick_coord(span, q.point_y);
    q.corner_c_x = pick_coord(span, q.point_x);
    q.corner_c_y = pick_coord(span, q.point_y);
    return q;
  endfunction

  task automatic send_query(input query_t q);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= q;
    do @(posedge clk_i); while (!query_taken);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_query(random_query());
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // corner values, degenerate shapes, edges on or parallel to the ray
    send_query(make_query(0, 0, 0, 0, 0, 0, 0, 0));
    send_query(make_query(-65536, -65536, -65536, -65536, -65536, -65536, -65536, -65536));
    send_query(make_query(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535));
    send_query(make_query(0, 0, -100, -50, 100, -50, 0, 100));
    send_query(make_query(500, 0, -100, -50, 100, -50, 0, 100));
    send_query(make_query(-100, -50, -100, -50, 100, -50, 0, 100));
    send_query(make_query(0, -50, -100, -50, 100, -50, 0, 100));
    send_query(make_query(0, 0, 10, 10, 20, 20, 30, -5));
    send_query(make_query(0, 0, 10, 0, 20, 10, -5, 30));
    send_query(make_query(0, 0, 7, -3, 7, -3, -4, 9));
    send_query(make_query(0, 0, 50, 50, 100, 0, 0, 100));
    send_query(make_query(-5, -5, 0, 0, 10, 10, 20, 20));
    send_query(make_query(0, 0, -65536, -65536, 65535, -65536, 0, 65535));
    send_query(make_query(-65536, -65536, 65535, -65536, -65536, 65535, 65535, 65535));
    send_query(make_query(65535, 65535, -65536, 65535, 65535, -65536, -65536, -65536));
    send_query(make_query(-65536, 65535, -65536, -65536, 65535, 0, 0, 65535));
    send_query(make_query(1, -1, -1, -65536, 65535, 65535, -65536, 1));
    send_query(make_query(-1, -1, 65535, -65536, -65536, 65535, 65535, 65535));

    run_random(110, 0, 0);

    // stall the sink long enough to back the unit up into its input
    hold_req = 1'b1;
    run_random(30, 0, 0);
    drain_results();

    run_random(110, 73, 0);
    run_random(110, 0, 73);
    run_random(110, 31, 31);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* point_in_triangle_ray_crossing_unit.f */
rtl/core/pitrc_pkg.sv
rtl/core/pitrc_edge.sv
rtl/core/point_in_triangle_ray_crossing_unit.sv
tb/sv/tb_top.sv
